// ----- rtl/core/ecwah_pkg.sv -----
// ecwah_pkg: shared types, sequencer step codes and sine polynomial constants
// for the envelope controlled wah filter; used by the controller, datapath and top

package ecwah_pkg;

  localparam int OP_W = 5;

  localparam logic [OP_W-1:0] OP_IDLE  = 5'd0;
  localparam logic [OP_W-1:0] OP_E0    = 5'd1;
  localparam logic [OP_W-1:0] OP_E1    = 5'd2;
  localparam logic [OP_W-1:0] OP_E2    = 5'd3;
  localparam logic [OP_W-1:0] OP_E3    = 5'd4;
  localparam logic [OP_W-1:0] OP_E4    = 5'd5;
  localparam logic [OP_W-1:0] OP_E5    = 5'd6;
  localparam logic [OP_W-1:0] OP_FCM   = 5'd7;
  localparam logic [OP_W-1:0] OP_FC    = 5'd8;
  localparam logic [OP_W-1:0] OP_TT    = 5'd9;
  localparam logic [OP_W-1:0] OP_TT2   = 5'd10;
  localparam logic [OP_W-1:0] OP_HMUL  = 5'd11;
  localparam logic [OP_W-1:0] OP_HSUB  = 5'd12;
  localparam logic [OP_W-1:0] OP_SMUL  = 5'd13;
  localparam logic [OP_W-1:0] OP_SFIN  = 5'd14;
  localparam logic [OP_W-1:0] OP_DINIT = 5'd15;
  localparam logic [OP_W-1:0] OP_DSTEP = 5'd16;
  localparam logic [OP_W-1:0] OP_DFIN  = 5'd17;
  localparam logic [OP_W-1:0] OP_L1    = 5'd18;
  localparam logic [OP_W-1:0] OP_L2    = 5'd19;
  localparam logic [OP_W-1:0] OP_L3    = 5'd20;
  localparam logic [OP_W-1:0] OP_L4    = 5'd21;
  localparam logic [OP_W-1:0] OP_L5    = 5'd22;
  localparam logic [OP_W-1:0] OP_L6    = 5'd23;
  localparam logic [OP_W-1:0] OP_L7    = 5'd24;
  localparam logic [OP_W-1:0] OP_L8    = 5'd25;
  localparam logic [OP_W-1:0] OP_L9    = 5'd26;
  localparam logic [OP_W-1:0] OP_L10   = 5'd27;
  localparam logic [OP_W-1:0] OP_L11   = 5'd28;
  localparam logic [OP_W-1:0] OP_L12   = 5'd29;
  localparam logic [OP_W-1:0] OP_L13   = 5'd30;
  localparam logic [OP_W-1:0] OP_L14   = 5'd31;

  localparam logic [3:0] REG_RELEASE  = 4'd0;
  localparam logic [3:0] REG_ATTACK   = 4'd1;
  localparam logic [3:0] REG_SPAN     = 4'd2;
  localparam logic [3:0] REG_FLOOR    = 4'd3;
  localparam logic [3:0] REG_DAMPING  = 4'd4;
  localparam logic [3:0] REG_PREGAIN  = 4'd5;
  localparam logic [3:0] REG_WETMIX   = 4'd6;
  localparam logic [3:0] REG_RESPONSE = 4'd7;

  localparam logic [1:0] RESP_LOW  = 2'd0;
  localparam logic [1:0] RESP_HIGH = 2'd2;

  localparam int DIV_STEPS = 33;

  localparam logic [17:0] COEF_ONE = 18'd65536;

  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026997;
  localparam logic [30:0] SIN_C9 = 31'd172272;

  typedef struct packed {
    logic [16:0] release_coeff;
    logic [16:0] attack_coeff;
    logic [15:0] sweep_span;
    logic [15:0] sweep_floor;
    logic [16:0] damping;
    logic [16:0] pre_gain;
    logic [16:0] wet_mix;
    logic [1:0]  response_select;
  } ecwah_cfg_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            load;
    logic            cos_pass;
    logic [1:0]      hidx;
    logic            commit;
  } ecwah_cmd_t;

  typedef struct packed {
    logic div_zero;
  } ecwah_stat_t;

endpackage

// ----- rtl/core/ecwah_ctrl.sv -----
// ecwah_ctrl: step sequencer for one sample, input and output handshakes
// depends on ecwah_pkg

module ecwah_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ecwah_pkg::ecwah_cmd_t cmd,
  input  ecwah_pkg::ecwah_stat_t stat
);
  import ecwah_pkg::*;

  logic [OP_W-1:0] state;
  logic [OP_W-1:0] state_next;
  logic            cos_pass;
  logic [1:0]      hidx;
  logic [5:0]      cnt;
  logic            can_commit;

  assign in_ready   = (state == OP_IDLE);
  assign can_commit = (state == OP_L14) && (!out_valid || out_ready);

  always_comb begin
    cmd.op       = state;
    cmd.load     = in_ready && in_valid;
    cmd.cos_pass = cos_pass;
    cmd.hidx     = hidx;
    cmd.commit   = can_commit;
  end

  always_comb begin
    state_next = state;
    case (state)
      OP_IDLE: begin
        if (in_valid) state_next = OP_E0;
      end
      OP_HSUB: begin
        state_next = (hidx == 2'd3) ? OP_SMUL : OP_HMUL;
      end
      OP_SFIN: begin
        state_next = cos_pass ? OP_DINIT : OP_TT;
      end
      OP_DINIT: begin
        state_next = stat.div_zero ? OP_DFIN : OP_DSTEP;
      end
      OP_DSTEP: begin
        if (cnt == 6'(DIV_STEPS - 1)) state_next = OP_DFIN;
      end
      OP_L14: begin
        if (can_commit) state_next = OP_IDLE;
      end
      default: begin
        state_next = state + 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= OP_IDLE;
      cos_pass  <= 1'b0;
      hidx      <= 2'd0;
      cnt       <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        OP_IDLE:  cos_pass <= 1'b0;
        OP_TT2:   hidx <= 2'd0;
        OP_HSUB:  hidx <= hidx + 1'b1;
        OP_SFIN:  cos_pass <= 1'b1;
        OP_DINIT: cnt <= 6'd0;
        OP_DSTEP: cnt <= cnt + 1'b1;
        default: ;
      endcase
      if (can_commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/ecwah_dp.sv -----
// ecwah_dp: filter state, shared 33x33 multiplier, sine evaluation and
// bit-serial divider; steered step by step by ecwah_ctrl, depends on ecwah_pkg

module ecwah_dp #(
  parameter int FRAC_BITS       = 16,
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ecwah_pkg::ecwah_cmd_t  cmd,
  output ecwah_pkg::ecwah_stat_t stat,
  input  ecwah_pkg::ecwah_cfg_t  cfg,
  input  logic signed [31:0]     sample_in,
  output logic signed [31:0]     sample_out
);
  import ecwah_pkg::*;

  localparam int TB = TRIG_TABLE_BITS;
  localparam logic [TB:0] SPAN = (TB+1)'(1) << TB;

  logic [31:0] x, xa, peak_hold, envelope_level, prefilter_delay, svf_low, svf_band;
  logic [31:0] tmp, b0, a1, xh, sum, pre, hp;
  logic signed [65:0] prod;
  logic signed [32:0] ma, mb;
  logic        mul_en;
  logic [TB+1:0] pp;
  logic [TB:0]   n;
  logic          nneg;
  logic [30:0]   t, t2, acc;
  logic signed [17:0] s, c;
  logic [32:0] num;
  logic [17:0] rem, den;
  logic        qneg, dz;

  logic [31:0] pc, ysum, fc, sel;
  logic [TB+1:0] pp_w, pcos_w;
  logic [TB:0]   n_sin, n_cos;
  logic          neg_sin, neg_cos;
  logic [30:0]   t_w, sq, hc;
  logic [31:0]   vsum;
  logic [17:0]   v, vcl;
  logic signed [17:0] sv;
  logic signed [18:0] d;
  logic [16:0] abs_s;
  logic [17:0] abs_d;
  logic [18:0] rem_sh;
  logic        qbit;
  logic signed [18:0] f;

  function automatic logic [TB:0] fold(input logic [TB+1:0] p);
    logic [TB:0] r;
    r = {1'b0, p[TB-1:0]};
    fold = p[TB] ? (SPAN - r) : r;
  endfunction

  function automatic logic signed [32:0] sx18(input logic [17:0] v18);
    sx18 = {{15{v18[17]}}, v18};
  endfunction

  function automatic logic [17:0] beta(input logic [16:0] a);
    beta = COEF_ONE - {1'b0, a};
  endfunction

  always_comb begin
    pc      = prod[47:16];
    ysum    = tmp + pc;
    fc      = prod[FRAC_BITS+31:FRAC_BITS] + {16'b0, cfg.sweep_floor};
    pp_w    = fc[16 -: TB+2];
    pcos_w  = pp + (TB+2)'(SPAN);
    n_sin   = fold(pp_w);
    neg_sin = pp_w[TB+1];
    n_cos   = fold(pcos_w);
    neg_cos = pcos_w[TB+1];
    t_w     = 31'(n) << (30 - TB);
    sq      = prod[60:30];
    vsum    = {1'b0, sq} + 32'd8192;
    v       = vsum[31:14];
    vcl     = (v > COEF_ONE) ? COEF_ONE : v;
    sv      = nneg ? -$signed(vcl) : $signed(vcl);
    case (cmd.hidx)
      2'd0:    hc = SIN_C7;
      2'd1:    hc = SIN_C5;
      2'd2:    hc = SIN_C3;
      default: hc = SIN_C1;
    endcase
    d       = 19'(s) + 19'(c);
    abs_s   = s[17] ? 17'(-s) : s[16:0];
    abs_d   = d[18] ? 18'(-d) : d[17:0];
    rem_sh  = {rem, num[32]};
    qbit    = (rem_sh >= {1'b0, den});
    f       = {s, 1'b0};
    case (cfg.response_select)
      RESP_LOW:  sel = svf_low;
      RESP_HIGH: sel = hp;
      default:   sel = svf_band;
    endcase
    stat.div_zero = (d == 19'sd0);
  end

  always_comb begin
    mul_en = 1'b1;
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_E0:   begin ma = sx18({1'b0, cfg.release_coeff}); mb = 33'(signed'(peak_hold)); end
      OP_E1:   begin ma = sx18(beta(cfg.release_coeff)); mb = 33'(signed'(xa)); end
      OP_E3:   begin ma = sx18({1'b0, cfg.attack_coeff}); mb = 33'(signed'(envelope_level)); end
      OP_E4:   begin ma = sx18(beta(cfg.attack_coeff)); mb = 33'(signed'(peak_hold)); end
      OP_FCM:  begin ma = 33'(signed'(envelope_level)); mb = {17'b0, cfg.sweep_span}; end
      OP_TT:   begin ma = {2'b0, t_w}; mb = {2'b0, t_w}; end
      OP_TT2:  begin ma = {2'b0, SIN_C9}; mb = {2'b0, sq}; end
      OP_HMUL: begin ma = {2'b0, acc}; mb = {2'b0, t2}; end
      OP_SMUL: begin ma = {2'b0, acc}; mb = {2'b0, t}; end
      OP_L1:   begin ma = 33'(signed'(a1)); mb = 33'(signed'(prefilter_delay)); end
      OP_L4:   begin ma = 33'(signed'(b0)); mb = 33'(signed'(sum)); end
      OP_L5:   begin ma = sx18({1'b0, cfg.pre_gain}); mb = 33'(signed'(pc)); end
      OP_L6:   begin ma = sx18({1'b0, cfg.damping}); mb = 33'(signed'(svf_band)); end
      OP_L8:   begin ma = 33'(f); mb = 33'(signed'(hp)); end
      OP_L10:  begin ma = 33'(f); mb = 33'(signed'(svf_band)); end
      OP_L12:  begin ma = sx18({1'b0, cfg.wet_mix}); mb = 33'(signed'(sel)); end
      OP_L13:  begin ma = sx18(beta(cfg.wet_mix)); mb = 33'(signed'(x)); end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_hold       <= '0;
      envelope_level  <= '0;
      prefilter_delay <= '0;
      svf_low         <= '0;
      svf_band        <= '0;
    end else begin
      case (cmd.op)
        OP_E2:  peak_hold <= ($signed(xa) > $signed(ysum)) ? xa : ysum;
        OP_E5:  envelope_level <= ysum;
        OP_L3:  prefilter_delay <= xh;
        OP_L9:  svf_band <= svf_band + pc;
        OP_L11: svf_low <= svf_low + pc;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x  <= sample_in;
      xa <= sample_in[31] ? -sample_in : sample_in;
    end
    case (cmd.op)
      OP_E1, OP_E4, OP_L13: tmp <= pc;
      OP_FC: begin
        pp   <= pp_w;
        n    <= n_sin;
        nneg <= neg_sin;
      end
      OP_TT: t <= t_w;
      OP_TT2: begin
        t2  <= sq;
        acc <= SIN_C9;
      end
      OP_HSUB: acc <= hc - sq;
      OP_SFIN: begin
        if (cmd.cos_pass) begin
          c <= sv;
        end else begin
          s    <= sv;
          n    <= n_cos;
          nneg <= neg_cos;
        end
      end
      OP_DINIT: begin
        num  <= {abs_s, 16'b0};
        den  <= abs_d;
        rem  <= '0;
        qneg <= s[17] ^ d[18];
        dz   <= stat.div_zero;
      end
      OP_DSTEP: begin
        rem <= qbit ? 18'(rem_sh - {1'b0, den}) : rem_sh[17:0];
        num <= {num[31:0], qbit};
      end
      OP_DFIN: begin
        if (dz) begin
          b0 <= '0;
          a1 <= {17'h1ffff, 15'b0} << 1;
        end else if (qneg) begin
          b0 <= (num > 33'h080000000) ? 32'h80000000 : -num[31:0];
          a1 <= ((num > 33'h080000000) ? 32'h80000000 - 32'd32768
                                       : -num[31:0] - 32'd32768) << 1;
        end else begin
          b0 <= (num > 33'h07fffffff) ? 32'h7fffffff : num[31:0];
          a1 <= ((num > 33'h07fffffff) ? 32'h7fffffff - 32'd32768
                                       : num[31:0] - 32'd32768) << 1;
        end
      end
      OP_L2: xh <= x - pc;
      OP_L3: sum <= xh + prefilter_delay;
      OP_L6: pre <= pc;
      OP_L7: hp <= pre - svf_low - pc;
      default: ;
    endcase
    if (cmd.commit) sample_out <= ysum;
  end

endmodule

// ----- rtl/core/envelope_controlled_wah_filter.sv -----
// Envelope controlled wah filter: one signed audio sample in, one mixed sample out.
// The time an item takes from acceptance to its result is set by the single
// shared 33x33 multiplier, through which every product including the two degree-9
// sine evaluations passes, and by the 33-step bit-serial divider that forms the
// lowpass coefficient; the divider steps are skipped when the sine and cosine of
// the center frequency cancel. The next item can be taken in the cycle after a
// result is written to the output register, while that result may still wait for
// out_ready, so a new sample is not accepted while the previous one is in work.
// Configuration writes take effect at once and are always accepted.

module envelope_controlled_wah_filter #(
  parameter int FRAC_BITS       = 16,
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] sample_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] sample_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import ecwah_pkg::*;

  ecwah_cfg_t  cfg;
  ecwah_cmd_t  cmd;
  ecwah_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.release_coeff   <= '0;
      cfg.attack_coeff    <= '0;
      cfg.sweep_span      <= '0;
      cfg.sweep_floor     <= '0;
      cfg.damping         <= 17'd13107;
      cfg.pre_gain        <= '0;
      cfg.wet_mix         <= 17'd65536;
      cfg.response_select <= 2'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RELEASE:  cfg.release_coeff   <= cfg_data[16:0];
        REG_ATTACK:   cfg.attack_coeff    <= cfg_data[16:0];
        REG_SPAN:     cfg.sweep_span      <= cfg_data[15:0];
        REG_FLOOR:    cfg.sweep_floor     <= cfg_data[15:0];
        REG_DAMPING:  cfg.damping         <= cfg_data[16:0];
        REG_PREGAIN:  cfg.pre_gain        <= cfg_data[16:0];
        REG_WETMIX:   cfg.wet_mix         <= cfg_data[16:0];
        REG_RESPONSE: cfg.response_select <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  ecwah_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  ecwah_dp #(
    .FRAC_BITS       (FRAC_BITS),
    .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg        (cfg),
    .sample_in  (sample_in),
    .sample_out (sample_out)
  );

endmodule

// ----- rtl/core/ecwah_chk.sv -----
// ecwah_chk: port-level checks of the wah filter handshakes over time
// bound to envelope_controlled_wah_filter below

module ecwah_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] sample_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while another is in work");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work");

endmodule

bind envelope_controlled_wah_filter ecwah_chk u_ecwah_chk (.*);

// ----- bench/testbench.sv -----
// testbench: self-checking bench for the envelope controlled wah filter
// predicts each output sample in its own fixed-point model and compares it
// depends on ecwah_pkg and envelope_controlled_wah_filter

`timescale 1ns / 100ps

module testbench;
  import ecwah_pkg::*;

  localparam int FB = 16;
  localparam int TB = 10;
  localparam longint ONE = 65536;
  localparam longint S1 = 1686629713;
  localparam longint S3 = 693598668;
  localparam longint S5 = 85569306;
  localparam longint S7 = 5026997;
  localparam longint S9 = 172272;
  localparam int LIMIT = 1200000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] sample_in = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] sample_out;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [3:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  envelope_controlled_wah_filter DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample_in(sample_in),
    .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // model copy of registers and filter state
  logic [16:0] m_release, m_attack, m_damping, m_gain, m_wet;
  logic [15:0] m_span, m_floor;
  logic [1:0] m_resp;
  logic [31:0] peak, env, pdel, slow, sband;

  logic [31:0] expected_samples[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_off = 0;
  int cycles = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d", what, $signed(got), $signed(want));
    errors++;
  endtask

  function automatic longint floor_shift(input longint v, input int sh);
    return v >>> sh;
  endfunction

  function automatic logic [31:0] coef_mul(input longint coef, input logic [31:0] sig);
    longint sv;
    sv = longint'($signed(sig));
    return 32'(floor_shift(coef * sv, 16));
  endfunction

  function automatic longint quarter_sine(input int n);
    logic [63:0] t, t2, acc, s;
    t = 64'(n) << (30 - TB);
    t2 = (t * t) >> 30;
    acc = S9;
    acc = S7 - ((acc * t2) >> 30);
    acc = S5 - ((acc * t2) >> 30);
    acc = S3 - ((acc * t2) >> 30);
    acc = S1 - ((acc * t2) >> 30);
    s = (t * acc) >> 30;
    s = (s + 8192) >> 14;
    if (s > ONE) s = ONE;
    return longint'(s);
  endfunction

  function automatic longint step_sine(input int p);
    int span, quad, r;
    longint v;
    span = 1 << TB;
    quad = (p >> TB) & 3;
    r = p & (span - 1);
    v = quarter_sine((quad & 1) ? span - r : r);
    return (quad & 2) ? -v : v;
  endfunction

  function automatic logic [31:0] wah_sample(input logic [31:0] x);
    logic [31:0] xa, y1, fc, xh, ylp, pre, hp, sel;
    longint s, c, d, b0, a1, f;
    int p, mask;
    mask = (4 << TB) - 1;
    xa = x[31] ? -x : x;
    y1 = coef_mul(m_release, peak) + coef_mul(ONE - m_release, xa);
    peak = ($signed(xa) > $signed(y1)) ? xa : y1;
    env = coef_mul(m_attack, env) + coef_mul(ONE - m_attack, peak);
    fc = 32'(floor_shift(longint'($signed(env)) * m_span, FB)) + m_floor;
    p = int'(fc >> (15 - TB)) & mask;
    s = step_sine(p);
    c = step_sine((p + (1 << TB)) & mask);
    d = s + c;
    b0 = (d == 0) ? 0 : (s * ONE) / d;
    if (b0 > 2147483647) b0 = 2147483647;
    if (b0 < -64'sd2147483648) b0 = -64'sd2147483648;
    a1 = longint'($signed(32'((b0 - ONE / 2) * 2)));
    xh = x - coef_mul(a1, pdel);
    ylp = coef_mul(b0, xh + pdel);
    pdel = xh;
    pre = coef_mul(m_gain, ylp);
    f = 2 * s;
    hp = pre - slow - coef_mul(m_damping, sband);
    sband = sband + coef_mul(f, hp);
    slow = slow + coef_mul(f, sband);
    if (m_resp == RESP_LOW) sel = slow;
    else if (m_resp == RESP_HIGH) sel = hp;
    else sel = sband;
    return coef_mul(m_wet, sel) + coef_mul(ONE - m_wet, x);
  endfunction

  task automatic send_sample(input logic [31:0] x);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    sample_in <= x;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_samples.push_back(wah_sample(x));
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_RELEASE: m_release = val[16:0];
      REG_ATTACK: m_attack = val[16:0];
      REG_SPAN: m_span = val[15:0];
      REG_FLOOR: m_floor = val[15:0];
      REG_DAMPING: m_damping = val[16:0];
      REG_PREGAIN: m_gain = val[16:0];
      REG_WETMIX: m_wet = val[16:0];
      REG_RESPONSE: m_resp = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic set_all(input logic [16:0] rel, input logic [16:0] att, input logic [15:0] span,
                         input logic [15:0] flr, input logic [16:0] damp,
                         input logic [16:0] gain, input logic [16:0] wet,
                         input logic [1:0] resp);
    drain();
    write_reg(REG_RELEASE, rel);
    write_reg(REG_ATTACK, att);
    write_reg(REG_SPAN, span);
    write_reg(REG_FLOOR, flr);
    write_reg(REG_DAMPING, damp);
    write_reg(REG_PREGAIN, gain);
    write_reg(REG_WETMIX, wet);
    write_reg(REG_RESPONSE, resp);
  endtask

  function automatic logic [31:0] audio_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  task automatic test_reset_defaults;
    send_sample(32'h0001_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h7fff_ffff);
    send_sample(0);
    send_sample(32'hffff_ffff);
  endtask

  task automatic test_directed;
    // high bits of data dropped, unknown index ignored
    drain();
    write_reg(4'd9, 32'hffff_ffff);
    set_all(17'h1ffff, 17'h1ffff, 16'hffff, 16'hffff, 17'h1ffff, 17'h1ffff, 17'h1ffff, 2'd3);
    write_reg(REG_WETMIX, 32'hfffe_8000);
    send_sample(32'h8000_0000);
    send_sample(32'h7fff_ffff);
    send_sample(32'h1234_5678);
    set_all(0, 0, 0, 16'd49152, 13107, 65536, 65536, RESP_LOW);  // pole at infinity
    send_sample(32'h0001_0000);
    send_sample(32'hfff0_0000);
    set_all(0, 0, 0, 16'd49120, 0, 65536, 0, RESP_HIGH);  // huge b0 next to the pole
    send_sample(32'h0000_8000);
    send_sample(32'h8000_0000);
    set_all(65536, 65536, 32768, 32768, 65536, 0, 32768, 2'd1);
    send_sample(32'h0100_0000);
    send_sample(32'hff00_0000);
    send_sample(32'h7fff_ffff);
  endtask

  task automatic random_phase(input int n, input int s_idle, input int r_idle);
    set_all($urandom_range(65536), $urandom_range(65536), $urandom_range(32768),
            $urandom_range(32768), $urandom_range(65536), $urandom_range(65536),
            $urandom_range(65536), $urandom_range(3));
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (n) send_sample(audio_value());
  endtask

  task automatic test_backpressure;
    drain();
    send_idle = 0;
    // receiver stalls for a fixed stretch while items keep coming
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
    join_none
    repeat (4) send_sample(audio_value());
  endtask

  // receiver
  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else if (hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_samples.size() == 0) report("unexpected item", sample_out, 0);
      else begin
        logic [31:0] want;
        want = expected_samples.pop_front();
        if (sample_out !== want) report("sample_out", sample_out, want);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    m_release = 0; m_attack = 0; m_span = 0; m_floor = 0;
    m_damping = 13107; m_gain = 0; m_wet = 65536; m_resp = 1;
    peak = 0; env = 0; pdel = 0; slow = 0; sband = 0;
    repeat (8) @(negedge clk);
    rst <= 0;
    test_reset_defaults();
    test_directed();
    for (int i = 0; i < 6; i++) random_phase(90, 36, 53);
    for (int i = 0; i < 6; i++) random_phase(90, 53, 36);
    test_backpressure();
    for (int i = 0; i < 6; i++) random_phase(90, 0, 0);
    drain();
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule
